// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SKT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define SKT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rst, prop, msg)
`define SKT_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// File: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// types and constants of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

   // table geometry
   localparam int CAPACITY    = 8;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // item field widths
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 3;
   localparam int COUNT_W  = 4;

   // one table entry in memory: key above handle
   localparam int ENTRY_W = KEY_W + HANDLE_BITS;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_MISS  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_PUT,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_REM_MOVE,
      ST_RESULT
   } state_type;

   // memory access request from the controller
   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

   // finished result handed to the output register
   typedef struct packed {
      logic                load;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [HANDLE_W-1:0] found_handle;
      logic [COUNT_W-1:0]  entry_count;
   } result_type;

endpackage

// File: hw/rtl/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if
// valid/ready channels for request and response items
// ----------------------------------------------------------------------------
interface skt_req_if;
   import skt_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [KEY_W-1:0]    key;
   logic [HANDLE_W-1:0] entry_handle;

   modport source (output valid, output kind, output key, output entry_handle,
                   input ready);
   modport sink   (input valid, input kind, input key, input entry_handle,
                   output ready);
endinterface

interface skt_rsp_if;
   import skt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [HANDLE_W-1:0] found_handle;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output position,
                   output found_handle, output entry_count, input ready);
   modport sink   (input valid, input status, input position,
                   input found_handle, input entry_count, output ready);
endinterface

// File: hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// bounded table of (key, handle) entries kept in ascending key order
// ----------------------------------------------------------------------------
// One request item in, one response item out. Insert places the entry after
// any equal keys, shifting larger keys up one slot; remove finds the key by
// binary search (probe at floor((low+high)/2)) and closes the gap; search
// reports the position and handle found. Entries live in a small ram with a
// registered read, so each compare or move acts on a read issued in the cycle
// before. Items are handled one at a time. An insert into an empty table
// writes the entry at once; otherwise it makes one move per entry shifted up.
// A search takes at most log2(capacity)+1 probes; a remove is the search
// followed by one move per entry moved down; a refused insert or a remove
// from an empty table goes straight to the result. A result that finds the
// output register still occupied waits until the item there is taken. A
// finished result sits in an output register, so the next request is
// accepted while it waits. The table is empty after reset; no clearing pass
// is run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_table (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_if,
   skt_rsp_if.source rsp_if
);
   import skt_pkg::*;

   // controller to ram and output register
   result_type           res;
   mem_req_type          mem_req;
   logic [ENTRY_W-1:0]   mem_rdata;
   logic                 out_free;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic [HANDLE_W-1:0]  found_ff, found_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   // entry store: key and handle side by side
   skt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   // insert, search and remove sequencing
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_free  (out_free),
      .res       (res),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // result may load when the register is empty or drains this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      position_in  = position_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      if (res.load) begin
         rsp_valid_in = 1'b1;
         status_in    = res.status;
         position_in  = res.position;
         found_in     = res.found_handle;
         count_in     = res.entry_count;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      position_ff <= position_in;
      found_ff    <= found_in;
      count_ff    <= count_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.position     = position_ff;
   assign rsp_if.found_handle = found_ff;
   assign rsp_if.entry_count  = count_ff;

   `SKT_ASSERT(a_load_free, clock, reset, res.load |-> (!rsp_valid_ff || rsp_if.ready), "result overwrites an item not yet taken")
   `SKT_ASSERT(a_error_fields, clock, reset, (res.load && res.status != STATUS_DONE) |-> (res.position == '0 && res.found_handle == '0), "refused item carries position or handle")

endmodule

// File: hw/rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// sequencer for insert shift, binary search and remove shift
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   skt_req_if.sink                      req_if,
   input  logic                         out_free,
   output skt_pkg::result_type          res,
   output skt_pkg::mem_req_type         mem_req,
   input  logic [skt_pkg::ENTRY_W-1:0]  mem_rdata
);
   import skt_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 remove_ff, remove_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hp_ff, hp_in;   // high bound plus one
   logic [IDX_W-1:0]     mid_ff, mid_in;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [HANDLE_BITS-1:0] found_ff, found_in;

   logic [KEY_W-1:0]       rd_key;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [CNT_W:0]         mid_sum;
   logic [IDX_W-1:0]       mid;

   assign rd_key    = mem_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hp_ff} - (CNT_W+1)'(1);
   assign mid       = IDX_W'(mid_sum >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      remove_ff <= remove_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hp_ff     <= hp_in;
      mid_ff    <= mid_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      remove_in = remove_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      hp_in     = hp_ff;
      mid_in    = mid_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;

      mem_req = '0;
      req_if.ready = (state_ff == ST_IDLE);

      res.load         = 1'b0;
      res.status       = status_ff;
      res.position     = POS_W'(pos_ff);
      res.found_handle = HANDLE_W'(found_ff);
      res.entry_count  = COUNT_W'(count_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               key_in    = req_if.key;
               handle_in = HANDLE_BITS'(req_if.entry_handle);
               remove_in = (req_if.kind == KIND_REMOVE);
               status_in = STATUS_DONE;
               pos_in    = '0;
               found_in  = '0;
               lo_in     = '0;
               hp_in     = count_ff;
               case (req_if.kind)
                  KIND_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_RESULT;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = ST_INS_PUT;
                     end else begin
                        mem_req.raddr = IDX_W'(count_ff - CNT_W'(1));
                        idx_in        = IDX_W'(count_ff);
                        state_in      = ST_INS_CHK;
                     end
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESULT;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  default: begin
                     state_in = ST_SRCH_RD;
                  end
               endcase
            end
         end

         ST_INS_CHK: begin
            // move a larger key up one slot, read the next one down
            if (rd_key > key_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = idx_ff;
               mem_req.wdata = mem_rdata;
               idx_in        = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  mem_req.raddr = idx_ff - IDX_W'(2);
               end
            end else begin
               state_in = ST_INS_PUT;
            end
         end

         ST_INS_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = {key_ff, handle_ff};
            count_in      = count_ff + CNT_W'(1);
            pos_in        = idx_ff;
            state_in      = ST_RESULT;
         end

         ST_SRCH_RD: begin
            if (lo_ff < hp_ff) begin
               mem_req.raddr = mid;
               mid_in        = mid;
               state_in      = ST_SRCH_CHK;
            end else begin
               status_in = STATUS_MISS;
               state_in  = ST_RESULT;
            end
         end

         ST_SRCH_CHK: begin
            if (rd_key == key_ff) begin
               pos_in   = mid_ff;
               found_in = rd_handle;
               if (!remove_ff) begin
                  state_in = ST_RESULT;
               end else if (CNT_W'(mid_ff) + CNT_W'(1) < count_ff) begin
                  // close the gap from the entry above
                  idx_in        = mid_ff;
                  mem_req.raddr = mid_ff + IDX_W'(1);
                  state_in      = ST_REM_MOVE;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_RESULT;
               end
            end else if (rd_key > key_ff) begin
               hp_in    = CNT_W'(mid_ff);
               state_in = ST_SRCH_RD;
            end else begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end

         ST_REM_MOVE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = mem_rdata;
            idx_in        = idx_ff + IDX_W'(1);
            if (CNT_W'(idx_ff) + CNT_W'(2) < count_ff) begin
               mem_req.raddr = IDX_W'(CNT_W'(idx_ff) + CNT_W'(2));
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               res.load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SKT_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(CAPACITY), "count above capacity")
   `SKT_ASSERT(a_write_busy, clock, reset, mem_req.we |-> (state_ff != ST_IDLE && state_ff != ST_RESULT), "table write while not busy")
   `SKT_ASSERT(a_full_refused, clock, reset, (req_if.valid && req_if.ready && req_if.kind == KIND_INSERT && count_ff == CNT_W'(CAPACITY)) |=> (state_ff == ST_RESULT && status_ff == STATUS_FULL), "insert into full table not refused")
   `SKT_ASSERT(a_probe_range, clock, reset, (state_ff == ST_SRCH_CHK) |-> (CNT_W'(mid_ff) < count_ff), "probe beyond filled entries")

endmodule

// File: test/sorted_key_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// self-checking bench for the sorted key table: a queue-fed driver offers
// insert, remove and search items, a monitor predicts each accepted item on a
// shadow table and checks every response item field by field
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
   import skt_pkg::*;

   // run shape
   localparam int RANDOM_OPS     = 1324;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 50;     // longer than the slowest remove
   localparam int PHASE_ONE_MARK = 480;    // accepted items before idling swaps
   localparam int PHASE_TWO_MARK = 960;    // accepted items before idling stops
   localparam int HOLDOFF_MARK   = 150;    // responses before the long stall
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PAUSE_MARK     = 700;    // items before the sender drains
   localparam int POOL_SIZE      = 12;

   // sender and receiver idle rates in percent, per phase
   localparam int BUSY_IDLE_PCT  = 81;
   localparam int LIGHT_IDLE_PCT = 36;

   // kind 3 is not a legal code, the block decodes it as a search
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // a name-like key, big-endian and zero padded, and keys at the compare edges
   localparam logic [KEY_W-1:0] KEY_NAME    = 64'h4D49_444E_414D_4500;
   localparam logic [KEY_W-1:0] KEY_MAX     = '1;
   localparam logic [KEY_W-1:0] KEY_TOP_BIT = 64'h8000_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_MID     = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } table_op_type;

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    position;
      logic [HANDLE_W-1:0] found_handle;
      logic [COUNT_W-1:0]  entry_count;
   } table_result_type;

   logic clock = 1'b0;
   logic reset;

   skt_req_if req_ch ();
   skt_rsp_if rsp_ch ();

   sorted_key_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // shadow table, updated once per accepted item
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0]       shadow_keys    [CAPACITY];
   logic [HANDLE_BITS-1:0] shadow_handles [CAPACITY];
   int                     shadow_fill;

   table_op_type     pending_ops[$];
   table_result_type expected_results[$];

   int  fail_count      = 0;
   int  cycle_count     = 0;
   int  ops_accepted    = 0;
   int  results_checked = 0;
   int  kind_tally   [3];    // insert, remove, search
   int  status_tally [4];
   int  directed_ops;

   // written by the monitor only as registered values, read by the driver
   logic settled;
   int   idle_phase;

   // binary search as the block does it, probing at floor((low+high)/2)
   function automatic int locate_key(logic [KEY_W-1:0] key);
      int low;
      int high;
      int mid;
      low  = 0;
      high = shadow_fill - 1;
      while (low <= high) begin
         mid = (low + high) / 2;
         if (shadow_keys[mid] == key) return mid;
         if (shadow_keys[mid] > key) high = mid - 1;
         else low = mid + 1;
      end
      return -1;
   endfunction

   // applies one item to the shadow table and returns the response it causes
   function automatic table_result_type apply_table_op(logic [KIND_W-1:0] kind,
                                                       logic [KEY_W-1:0] key,
                                                       logic [HANDLE_W-1:0] handle);
      table_result_type r;
      int               at;
      int               i;
      r.status       = STATUS_DONE;
      r.position     = '0;
      r.found_handle = '0;
      if (kind[1]) begin
         // search, and the unused code, which the block also treats as a search
         kind_tally[2]++;
         at = locate_key(key);
         if (at < 0) begin
            r.status = STATUS_MISS;
         end else begin
            r.position     = at[POS_W-1:0];
            r.found_handle = HANDLE_W'(shadow_handles[at]);
         end
      end else if (kind == KIND_REMOVE) begin
         kind_tally[1]++;
         if (shadow_fill == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            at = locate_key(key);
            if (at < 0) begin
               r.status = STATUS_MISS;
            end else begin
               r.position     = at[POS_W-1:0];
               r.found_handle = HANDLE_W'(shadow_handles[at]);
               // close the gap
               for (i = at; i + 1 < shadow_fill; i++) begin
                  shadow_keys[i]    = shadow_keys[i + 1];
                  shadow_handles[i] = shadow_handles[i + 1];
               end
               shadow_fill--;
            end
         end
      end else begin
         kind_tally[0]++;
         if (shadow_fill >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            // larger keys move up, equal keys stay below the new entry
            i = shadow_fill;
            while (i > 0 && shadow_keys[i - 1] > key) begin
               shadow_keys[i]    = shadow_keys[i - 1];
               shadow_handles[i] = shadow_handles[i - 1];
               i--;
            end
            shadow_keys[i]    = key;
            shadow_handles[i] = handle[HANDLE_BITS-1:0];
            shadow_fill++;
            r.position = i[POS_W-1:0];
         end
      end
      r.entry_count = shadow_fill[COUNT_W-1:0];
      return r;
   endfunction

   function automatic bit idle_now(int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic compare_field(string name, logic [KEY_W-1:0] want,
                                logic [KEY_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic queue_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [HANDLE_W-1:0] handle);
      pending_ops.push_back('{kind: kind, key: key, handle: handle});
   endtask

   // ---------------------------------------------------------------------
   // driver: unless idling or paused, offers the next pending item when the channel is free
   // ---------------------------------------------------------------------
   int sent_count;
   bit drain_pause;

   always @(posedge clock) begin
      table_op_type op;
      int           pct;
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.kind         <= KIND_INSERT;
         req_ch.key          <= '0;
         req_ch.entry_handle <= '0;
         sent_count  = 0;
         drain_pause = 1'b0;
      end else begin
         // release before the set below, so a pause set at this edge is not released at once
         if (drain_pause && settled) drain_pause = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            sent_count++;
            // hold back until every response is in
            if (sent_count == PAUSE_MARK) drain_pause = 1'b1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            pct = (idle_phase == 0) ? LIGHT_IDLE_PCT :
                  (idle_phase == 1) ? BUSY_IDLE_PCT : 0;
            if (!drain_pause && pending_ops.size() != 0 && !idle_now(pct)) begin
               op = pending_ops.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.kind         <= op.kind;
               req_ch.key          <= op.key;
               req_ch.entry_handle <= op.handle;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks responses, predicts accepted items, drives ready
   // ---------------------------------------------------------------------
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   always @(posedge clock) begin
      table_result_type want;
      int               pct;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         settled      <= 1'b1;
         idle_phase   <= 0;
      end else begin
         // check first: a response never belongs to the item taken this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("response item with no request outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", want.status, rsp_ch.status);
               compare_field("position", want.position, rsp_ch.position);
               compare_field("found_handle", want.found_handle, rsp_ch.found_handle);
               compare_field("entry_count", want.entry_count, rsp_ch.entry_count);
               results_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = apply_table_op(req_ch.kind, req_ch.key, req_ch.entry_handle);
            status_tally[want.status]++;
            expected_results.push_back(want);
            ops_accepted++;
         end
         settled    <= (expected_results.size() == 0);
         idle_phase <= (ops_accepted < PHASE_ONE_MARK) ? 0 :
                       (ops_accepted < PHASE_TWO_MARK) ? 1 : 2;

         // long stall once, so the block backs up and drops req ready
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!holdoff_done && results_checked >= HOLDOFF_MARK) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            pct = (idle_phase == 0) ? BUSY_IDLE_PCT :
                  (idle_phase == 1) ? LIGHT_IDLE_PCT : 0;
            rsp_ch.ready <= !idle_now(pct);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $error("timeout with %0d items pending and %0d responses outstanding",
             pending_ops.size(), expected_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      logic [KEY_W-1:0]    key_pool [POOL_SIZE];
      logic [KEY_W-1:0]    key;
      logic [KIND_W-1:0]   kind;
      int                  mode;
      int                  pick;
      int                  n;
      int                  j;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_INSERT;
      req_ch.key          = '0;
      req_ch.entry_handle = '0;
      rsp_ch.ready        = 1'b0;
      foreach (kind_tally[i]) kind_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      shadow_fill = 0;

      // empty table: search misses, remove is refused
      queue_op(KIND_SEARCH, 64'd5, 16'h0000);
      queue_op(KIND_REMOVE, 64'd5, 16'h0000);
      // fill to capacity with extreme keys and three equal names
      queue_op(KIND_INSERT, KEY_MAX, 16'hFFFF);
      queue_op(KIND_INSERT, 64'd0, 16'h0000);
      queue_op(KIND_INSERT, KEY_NAME, 16'h1234);
      queue_op(KIND_INSERT, KEY_NAME, 16'h5678);
      queue_op(KIND_INSERT, KEY_NAME, 16'h9ABC);
      queue_op(KIND_INSERT, 64'd5, 16'h0005);
      queue_op(KIND_INSERT, KEY_TOP_BIT, 16'h8000);
      queue_op(KIND_INSERT, KEY_MID, 16'h7FFF);
      // full table refuses
      queue_op(KIND_INSERT, 64'd7, 16'hAAAA);
      // duplicate search, unused kind, absent key search and remove
      queue_op(KIND_SEARCH, KEY_NAME, 16'h0000);
      queue_op(KIND_UNUSED, 64'd0, 16'h5555);
      queue_op(KIND_SEARCH, 64'd6, 16'h0000);
      queue_op(KIND_REMOVE, 64'd6, 16'h0000);
      // drain: last, first, then middle entries and duplicates, then remove and search on the empty table
      queue_op(KIND_REMOVE, KEY_MAX, 16'h0000);
      queue_op(KIND_REMOVE, 64'd0, 16'h0000);
      queue_op(KIND_REMOVE, KEY_NAME, 16'h0000);
      queue_op(KIND_SEARCH, KEY_NAME, 16'h0000);
      queue_op(KIND_REMOVE, 64'd5, 16'h0000);
      queue_op(KIND_REMOVE, KEY_NAME, 16'h0000);
      queue_op(KIND_REMOVE, KEY_TOP_BIT, 16'h0000);
      queue_op(KIND_REMOVE, KEY_MID, 16'h0000);
      queue_op(KIND_REMOVE, KEY_NAME, 16'h0000);
      queue_op(KIND_REMOVE, 64'd0, 16'h0000);
      queue_op(KIND_SEARCH, KEY_MAX, 16'h0000);
      directed_ops = pending_ops.size();

      // random part: a small key pool keeps removes and searches hitting,
      // modes lean toward filling or draining so the count sweeps 0..8
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      key_pool[2] = KEY_NAME;
      key_pool[3] = KEY_TOP_BIT;
      mode = 2;
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) mode = $urandom_range(2);
         if (n % 100 == 0) begin
            for (j = 4; j < POOL_SIZE; j++) key_pool[j] = {$urandom, $urandom};
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            kind = KIND_W'($urandom_range(3));     // noise, unused code included
         end else begin
            pick = $urandom_range(99);
            case (mode)
               0: kind = (pick < 65) ? KIND_INSERT :
                         (pick < 85) ? KIND_REMOVE : KIND_SEARCH;
               1: kind = (pick < 20) ? KIND_INSERT :
                         (pick < 80) ? KIND_REMOVE : KIND_SEARCH;
               default: kind = (pick < 40) ? KIND_INSERT :
                               (pick < 70) ? KIND_REMOVE : KIND_SEARCH;
            endcase
         end
         pick = $urandom_range(99);
         key  = key_pool[$urandom_range(POOL_SIZE - 1)];
         // neighbors of pool keys probe the compare edges; some keys are fully random
         if (pick >= 90) key = {$urandom, $urandom};
         else if (pick >= 84) key = key + 64'd1;
         else if (pick >= 78) key = key - 64'd1;
         queue_op(kind, key, HANDLE_W'($urandom_range(16'hFFFF)));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_ch.valid) @(posedge clock);
      while (!settled || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses (%0d directed): %0d insert, %0d remove, %0d search",
               results_checked, directed_ops, kind_tally[0], kind_tally[1], kind_tally[2]);
      $display("outcomes: %0d done, %0d full, %0d empty, %0d key missing",
               status_tally[STATUS_DONE], status_tally[STATUS_FULL],
               status_tally[STATUS_EMPTY], status_tally[STATUS_MISS]);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/skt_pkg.sv
hw/rtl/skt_if.sv
hw/rtl/skt_ram.sv
hw/rtl/skt_ctrl.sv
hw/rtl/sorted_key_table.sv
test/sorted_key_table_tb.sv
